[hdl/clie_pkg.sv]
package clie_pkg;

  typedef enum logic [1:0] {
    OP_RAW  = 2'd0,
    OP_DEC  = 2'd1,
    OP_GOTO = 2'd2,
    OP_BCD  = 2'd3
  } op_e;

  // LCD bytes per request, at most
  localparam int unsigned SLOTS = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [6:0] DIGIT_MAX  = 7'd9;

  // floor(v / d) == (v * RECIP) >> SHIFT for every 16-bit v
  localparam logic [16:0] RECIP_10   = 17'd52429;
  localparam int unsigned SHIFT_10   = 19;
  localparam logic [17:0] RECIP_100  = 18'd167773;
  localparam int unsigned SHIFT_100  = 24;
  localparam logic [16:0] RECIP_1000 = 17'd67109;
  localparam int unsigned SHIFT_1000 = 26;

  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    logic [SLOTS-1:0]      mask;
    logic                  rs;
    logic                  rw;
    logic                  bl;
  } lcd_entry_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      2'd3:    base = 8'hD4;
      default: base = 8'h80;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CHAR_ZERO | {4'h0, d};
  endfunction

endpackage

[hdl/clie_if.sv]
interface clie_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] value;
  logic [2:0]  digit_count;
  logic [4:0]  column;
  logic [1:0]  row;
  logic        reg_select;
  logic        read_write;
  logic        backlight;

  modport source (
    output valid, op, value, digit_count, column, row, reg_select, read_write, backlight,
    input  ready
  );
  modport sink (
    input  valid, op, value, digit_count, column, row, reg_select, read_write, backlight,
    output ready
  );
endinterface

interface clie_exp_if;
  logic       valid;
  logic       ready;
  logic [7:0] expander_byte;
  logic       last;

  modport source (output valid, expander_byte, last, input ready);
  modport sink (input valid, expander_byte, last, output ready);
endinterface

[hdl/clie_front.sv]
module clie_front import clie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  clie_req_if.sink   req_i,
  output lcd_entry_t entry_o,
  output logic       entry_valid_o,
  input  logic       entry_ready_i
);

  logic        s1_valid_q;
  op_e         op_q;
  logic [15:0] value_q;
  logic [2:0]  count_q;
  logic [4:0]  column_q;
  logic [1:0]  row_q;
  logic        rs_q;
  logic        rw_q;
  logic        bl_q;
  logic [12:0] q10_q;
  logic [9:0]  q100_q;
  logic [6:0]  q1000_q;

  logic [32:0] p10;
  logic [33:0] p100;
  logic [32:0] p1000;
  logic        accept;

  assign req_i.ready = !s1_valid_q || entry_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  assign p10   = 33'(req_i.value) * 33'(RECIP_10);
  assign p100  = 34'(req_i.value) * 34'(RECIP_100);
  assign p1000 = 33'(req_i.value) * 33'(RECIP_1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(req_i.op);
      value_q  <= req_i.value;
      count_q  <= req_i.digit_count;
      column_q <= req_i.column;
      row_q    <= req_i.row;
      rs_q     <= req_i.reg_select;
      rw_q     <= req_i.read_write;
      bl_q     <= req_i.backlight;
      q10_q    <= p10[SHIFT_10 +: 13];
      q100_q   <= p100[SHIFT_100 +: 10];
      q1000_q  <= p1000[SHIFT_1000 +: 7];
    end
  end

  // remainders give the decimal digits
  logic [15:0] units_w;
  logic [12:0] tens_w;
  logic [9:0]  hund_w;
  logic [3:0]  units;
  logic [3:0]  tens;
  logic [3:0]  hund;
  logic        thou_zero;
  logic        thou_ok;
  logic        bin1;
  logic        bin2;
  logic        blank0;
  logic        blank1;
  logic        blank2;
  lcd_entry_t  entry;

  assign units_w = value_q - 16'(q10_q) * 16'd10;
  assign tens_w  = q10_q - 13'(q100_q) * 13'd10;
  assign hund_w  = q100_q - 10'(q1000_q) * 10'd10;
  assign units   = units_w[3:0];
  assign tens    = tens_w[3:0];
  assign hund    = hund_w[3:0];

  assign thou_zero = (q1000_q == 7'd0);
  assign thou_ok   = (q1000_q <= DIGIT_MAX);

  // with three or four digits shown, blanking runs from the leading digit while the digits stay zero; units always show
  assign blank0 = thou_zero;
  assign bin1   = (count_q == 3'd4) ? blank0 : 1'b1;
  assign blank1 = bin1 && (hund == 4'd0);
  assign bin2   = (count_q == 3'd3 || count_q == 3'd4) && blank1;
  assign blank2 = bin2 && (tens == 4'd0);

  always_comb begin
    entry       = '0;
    entry.bytes = '0;
    case (op_q)
      OP_RAW: begin
        entry.bytes[0] = value_q[7:0];
        entry.mask     = 4'b0001;
        entry.rs       = rs_q;
        entry.rw       = rw_q;
        entry.bl       = bl_q;
      end
      OP_DEC: begin
        entry.rs       = 1'b1;
        entry.rw       = 1'b0;
        entry.bl       = 1'b1;
        entry.bytes[0] = blank0 ? CHAR_SPACE : digit_char(q1000_q[3:0]);
        entry.bytes[1] = blank1 ? CHAR_SPACE : digit_char(hund);
        entry.bytes[2] = blank2 ? CHAR_SPACE : digit_char(tens);
        entry.bytes[3] = digit_char(units);
        entry.mask[0]  = (count_q == 3'd4) && (blank0 || thou_ok);
        entry.mask[1]  = (count_q == 3'd3) || (count_q == 3'd4);
        entry.mask[2]  = (count_q >= 3'd2) && (count_q <= 3'd4);
        entry.mask[3]  = (count_q >= 3'd1) && (count_q <= 3'd4);
      end
      OP_GOTO: begin
        entry.bytes[0] = row_base(row_q) + {3'b000, column_q};
        entry.mask     = 4'b0001;
        entry.rs       = 1'b0;
        entry.rw       = 1'b0;
        entry.bl       = 1'b1;
      end
      OP_BCD: begin
        entry.bytes[0] = digit_char(value_q[7:4]);
        entry.bytes[1] = digit_char(value_q[3:0]);
        entry.mask[0]  = (value_q[7:4] <= DIGIT_MAX[3:0]);
        entry.mask[1]  = (value_q[3:0] <= DIGIT_MAX[3:0]);
        entry.rs       = 1'b1;
        entry.rw       = 1'b0;
        entry.bl       = bl_q;
      end
      default: begin
        entry = '0;
      end
    endcase
  end

  assign entry_o       = entry;
  assign entry_valid_o = s1_valid_q;

endmodule

[hdl/clie_queue.sv]
module clie_queue import clie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lcd_entry_t push_data_i,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  output lcd_entry_t pop_data_o,
  output logic       pop_valid_o,
  input  logic       pop_i
);

  lcd_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/clie_back.sv]
module clie_back import clie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lcd_entry_t entry_i,
  input  logic       entry_valid_i,
  output logic       entry_pop_o,
  clie_exp_if.source exp_o
);

  lcd_entry_t       cur_q;
  logic [SLOTS-1:0] mask_q;
  logic [1:0]       phase_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;

  logic [1:0]       sel;
  logic [SLOTS-1:0] sel_bit;
  logic [7:0]       lcd_byte;
  logic [3:0]       nib;
  logic             have;
  logic             load;
  logic             advance;
  logic             final_byte;
  logic             pop;

  always_comb begin
    if (mask_q[0]) begin
      sel = 2'd0;
    end else if (mask_q[1]) begin
      sel = 2'd1;
    end else if (mask_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign sel_bit    = SLOTS'(1) << sel;
  assign lcd_byte   = cur_q.bytes[sel];
  assign nib        = phase_q[1] ? lcd_byte[3:0] : lcd_byte[7:4];
  assign have       = (mask_q != '0);
  assign load       = !out_valid_q || exp_o.ready;
  assign advance    = load && have;
  assign final_byte = (phase_q == 2'd3) && ((mask_q & ~sel_bit) == '0);
  // fetch the next request as the current one runs out
  assign pop        = entry_valid_i && (!have || (advance && final_byte));

  assign entry_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= have;
      end
      if (pop) begin
        mask_q  <= entry_i.mask;
        phase_q <= 2'd0;
      end else if (advance) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          mask_q <= mask_q & ~sel_bit;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= entry_i;
    end
    if (advance) begin
      // EN high on the first beat of each nibble, low on the second
      out_byte_q <= {nib, cur_q.bl, ~phase_q[0], cur_q.rw, cur_q.rs};
      out_last_q <= final_byte;
    end
  end

  assign exp_o.valid         = out_valid_q;
  assign exp_o.expander_byte = out_byte_q;
  assign exp_o.last          = out_last_q;

endmodule

[hdl/char_lcd_i2c_expander_formatter.sv]
// Channel    Dir  Contents
// req_i      in   op, value, digit_count, column, row, reg_select, read_write, backlight
// exp_o      out  expander_byte, last (one byte per request beat)
//
// A request emits 4 expander bytes per LCD byte, 0 to 16 in all, one per cycle while exp_o.ready
// holds; that output register sets the rate.
// A request reaches its first byte through the digit stage, the two-entry queue,
// the back-end entry register and the output register.
// Requests that emit nothing still take one queue slot and a turn of the back end.
// Reset is asynchronous, active low, and empties the pipeline and queue.
// A stalled output holds its byte; the front and queue keep taking requests until full.
module char_lcd_i2c_expander_formatter import clie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  clie_req_if.sink   req_i,
  clie_exp_if.source exp_o
);

  lcd_entry_t front_entry;
  logic       front_valid;
  logic       queue_ready;
  lcd_entry_t queue_entry;
  logic       queue_valid;
  logic       queue_pop;

  clie_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .entry_o       (front_entry),
    .entry_valid_o (front_valid),
    .entry_ready_i (queue_ready)
  );

  clie_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_entry),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .pop_data_o   (queue_entry),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop)
  );

  clie_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (queue_entry),
    .entry_valid_i (queue_valid),
    .entry_pop_o   (queue_pop),
    .exp_o         (exp_o)
  );

endmodule

[hdl/clie_checker.sv]
module clie_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       exp_valid_i,
  input logic       exp_ready_i,
  input logic [7:0] exp_byte_i,
  input logic       exp_last_i
);

  // hold a stalled byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_valid_i && !exp_ready_i |=> exp_valid_i && $stable(exp_byte_i) && $stable(exp_last_i))
    else $error("stalled expander byte changed");

  // a strobe byte is followed at once by its EN-low twin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_valid_i && exp_ready_i && exp_byte_i[2] |=>
      exp_valid_i && !exp_byte_i[2] && exp_byte_i[7:3] == $past(exp_byte_i[7:3]) &&
      exp_byte_i[1:0] == $past(exp_byte_i[1:0]))
    else $error("EN-high byte not followed by matching EN-low byte");

  // the final byte of a request always drops EN
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_valid_i && exp_last_i |-> !exp_byte_i[2])
    else $error("last flag on an EN-high byte");

  // an EN-high byte never closes a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_valid_i && exp_ready_i && exp_byte_i[2] |-> !exp_last_i)
    else $error("request ended mid nibble");

endmodule

bind char_lcd_i2c_expander_formatter clie_checker u_clie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .exp_valid_i (exp_o.valid),
  .exp_ready_i (exp_o.ready),
  .exp_byte_i  (exp_o.expander_byte),
  .exp_last_i  (exp_o.last)
);

[sim/tb.sv]
module tb;
  import clie_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 435;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam logic [3:0][7:0] ROW_ADDR = {8'hD4, 8'h94, 8'hC0, 8'h80};
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [3:0] EN_MASK     = 4'b1011;
  localparam int         PREDICTED   = -1;

  typedef struct packed {
    op_e         op;
    logic [15:0] value;
    logic [2:0]  digit_count;
    logic [4:0]  column;
    logic [1:0]  row;
    logic        reg_select;
    logic        read_write;
    logic        backlight;
  } lcd_req_t;

  // typed rows carry their expander bytes, first one in the top byte
  typedef struct packed {
    lcd_req_t    req;
    logic        typed;
    logic [2:0]  typed_n;
    logic [31:0] typed_bytes;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } expander_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  clie_req_if req_if ();
  clie_exp_if exp_if ();

  char_lcd_i2c_expander_formatter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .exp_o  (exp_if)
  );

  expander_beat_t pending_beats[$];
  stim_row_t      stim_table[$];
  stim_row_t      cur_row;
  int unsigned    fail_count  = 0;
  int unsigned    cycle_count = 0;
  bit             src_idles   = 1'b0;
  bit             sink_idles  = 1'b0;
  bit             hold_req    = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Work out the expander bytes a request should produce and queue them.
  function automatic void predict_beats(input lcd_req_t r);
    logic [7:0]  chars [4];
    logic [3:0]  lines;
    logic [3:0]  nib;
    int unsigned digs [4];
    int unsigned n;
    int unsigned v;
    logic        blank;
    n = 0;
    v = r.value;
    lines = 4'b1101;
    case (r.op)
      OP_RAW: begin
        chars[0] = r.value[7:0];
        n = 1;
        lines = {r.backlight, 1'b1, r.read_write, r.reg_select};
      end
      OP_DEC: begin
        digs[0] = v / 1000;
        digs[1] = (v / 100) % 10;
        digs[2] = (v / 10) % 10;
        digs[3] = v % 10;
        if (r.digit_count >= 3'd1 && r.digit_count <= 3'd4) begin
          blank = (r.digit_count >= 3'd3);
          for (int k = 4 - r.digit_count; k < 4; k++) begin
            // blank leading zeros only while everything before was blank
            if (blank && k < 3 && digs[k] == 0) begin
              chars[n] = ASCII_SPACE;
              n = n + 1;
            end else begin
              blank = 1'b0;
              if (digs[k] <= 9) begin
                chars[n] = ASCII_ZERO + 8'(digs[k]);
                n = n + 1;
              end
            end
          end
        end
      end
      OP_GOTO: begin
        chars[0] = ROW_ADDR[r.row] + {3'b000, r.column};
        n = 1;
        lines = 4'b1100;
      end
      default: begin
        lines = {r.backlight, 3'b101};
        if (r.value[7:4] <= 4'd9) begin
          chars[n] = ASCII_ZERO + {4'h0, r.value[7:4]};
          n = n + 1;
        end
        if (r.value[3:0] <= 4'd9) begin
          chars[n] = ASCII_ZERO + {4'h0, r.value[3:0]};
          n = n + 1;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      for (int h = 0; h < 2; h++) begin
        nib = (h == 0) ? chars[k][7:4] : chars[k][3:0];
        pending_beats.push_back('{code: {nib, lines}, last: 1'b0});
        pending_beats.push_back('{code: {nib, lines & EN_MASK},
                                  last: (k == n - 1) && (h == 1)});
      end
    end
  endfunction

  function automatic void note_request(input stim_row_t s);
    if (s.typed) begin
      for (int k = 0; k < s.typed_n; k++)
        pending_beats.push_back('{code: s.typed_bytes[31 - 8 * k -: 8],
                                  last: (k == s.typed_n - 1)});
    end else begin
      predict_beats(s.req);
    end
  endfunction

  function automatic void check_beat(input logic [7:0] code, input logic last);
    expander_beat_t want;
    if (pending_beats.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected expander byte %h last %b", code, last);
    end else begin
      want = pending_beats.pop_front();
      if (code !== want.code) begin
        fail_count++;
        if (fail_count <= 10)
          $display("expander byte: expected %h, got %h", want.code, code);
      end
      if (last !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("last flag: expected %b, got %b (byte %h)", want.last, last, code);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        note_request(cur_row);
      if (exp_if.valid && exp_if.ready)
        check_beat(exp_if.expander_byte, exp_if.last);
    end
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
  endfunction

  function automatic void add_row(input op_e op, input logic [15:0] value,
                                  input logic [2:0] dcount, input logic [4:0] col,
                                  input logic [1:0] row, input logic rs, input logic rw,
                                  input logic bl, input int n, input logic [31:0] bytes);
    stim_row_t s;
    s.req         = '{op, value, dcount, col, row, rs, rw, bl};
    s.typed       = (n != PREDICTED);
    s.typed_n     = (n == PREDICTED) ? 3'd0 : 3'(n);
    s.typed_bytes = bytes;
    stim_table.push_back(s);
  endfunction

  function automatic lcd_req_t random_request();
    lcd_req_t r;
    r.op = op_e'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       r.value = 16'($urandom);
      1:       r.value = 16'($urandom_range(0, 9999));
      2:       r.value = 16'($urandom_range(0, 120));
      default: r.value = {8'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endcase
    // mostly well-formed BCD for the BCD op
    if (r.op == OP_BCD && $urandom_range(0, 3) != 0)
      r.value[7:0] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    r.digit_count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
    r.column     = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 19));
    r.row        = 2'($urandom_range(0, 3));
    r.reg_select = 1'($urandom);
    r.read_write = 1'($urandom);
    r.backlight  = 1'($urandom);
    return r;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_request(input stim_row_t s);
    int unsigned gap;
    gap = src_idles ? gap_len() : 0;
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_row            = s;
    req_if.op          = s.req.op;
    req_if.value       = s.req.value;
    req_if.digit_count = s.req.digit_count;
    req_if.column      = s.req.column;
    req_if.row         = s.req.row;
    req_if.reg_select  = s.req.reg_select;
    req_if.read_write  = s.req.read_write;
    req_if.backlight   = s.req.backlight;
    req_if.valid       = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req_if.valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Output side: random stalls, plus one long hold when asked.
  initial begin
    exp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        exp_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idles && $urandom_range(0, 3) == 0) begin
        exp_if.ready = 1'b0;
        repeat (gap_len() + 1) @(negedge clk_i);
      end
      exp_if.ready = 1'b1;
    end
  end

  initial begin
    stim_row_t s;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_RAW;
    req_if.value       = '0;
    req_if.digit_count = '0;
    req_if.column      = '0;
    req_if.row         = '0;
    req_if.reg_select  = 1'b0;
    req_if.read_write  = 1'b0;
    req_if.backlight   = 1'b0;
    cur_row            = '0;

    // extremes of each op, blanking, bad digit counts and digits above nine
    add_row(OP_RAW,  16'h00FF, 3'd0, 5'd0,  2'd0, 1'b1, 1'b1, 1'b1, 4, 32'hFFFB_FFFB);
    add_row(OP_RAW,  16'h0000, 3'd0, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, 4, 32'h0400_0400);
    add_row(OP_RAW,  16'h5AA5, 3'd7, 5'd31, 2'd3, 1'b1, 1'b0, 1'b1, 4, 32'hADA9_5D59);
    add_row(OP_RAW,  16'hFF3C, 3'd4, 5'd7,  2'd1, 1'b0, 1'b1, 1'b0, PREDICTED, '0);
    add_row(OP_GOTO, 16'h0000, 3'd0, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, 4, 32'h8C88_0C08);
    add_row(OP_GOTO, 16'hFFFF, 3'd7, 5'd19, 2'd3, 1'b1, 1'b1, 1'b0, 4, 32'hECE8_7C78);
    add_row(OP_GOTO, 16'h1234, 3'd2, 5'd31, 2'd1, 1'b0, 1'b0, 1'b1, PREDICTED, '0);
    add_row(OP_GOTO, 16'h0000, 3'd0, 5'd31, 2'd3, 1'b1, 1'b1, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd1234, 3'd0, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, 0, '0);
    add_row(OP_DEC,  16'd1234, 3'd5, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, 0, '0);
    add_row(OP_DEC,  16'd9999, 3'd7, 5'd0,  2'd0, 1'b1, 1'b1, 1'b0, 0, '0);
    add_row(OP_DEC,  16'hFFFF, 3'd1, 5'd0,  2'd0, 1'b0, 1'b1, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd7,    3'd2, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd0,    3'd3, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd5,    3'd3, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd0,    3'd4, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'hFFFF, 3'd4, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd9999, 3'd4, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd10000, 3'd4, 5'd0, 2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd1005, 3'd4, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_DEC,  16'd80,   3'd4, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);
    add_row(OP_BCD,  16'h0059, 3'd0, 5'd0,  2'd0, 1'b1, 1'b1, 1'b0, PREDICTED, '0);
    add_row(OP_BCD,  16'h00FF, 3'd0, 5'd0,  2'd0, 1'b0, 1'b0, 1'b1, 0, '0);
    add_row(OP_BCD,  16'hFF0A, 3'd3, 5'd0,  2'd0, 1'b0, 1'b0, 1'b1, PREDICTED, '0);
    add_row(OP_BCD,  16'h00A7, 3'd0, 5'd0,  2'd0, 1'b0, 1'b0, 1'b0, PREDICTED, '0);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    src_idles  = 1'b1;
    sink_idles = 1'b1;
    foreach (stim_table[i])
      send_request(stim_table[i]);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 0) begin
        src_idles  = 1'b0;
        sink_idles = 1'b0;
      end else if (i == 80) begin
        src_idles  = 1'b1;
        sink_idles = 1'b1;
      end else if (i == 160) begin
        // keep offering requests while the output is held off
        src_idles = 1'b0;
        hold_req  = 1'b1;
      end else if (i == 240) begin
        drain_results();
        src_idles = 1'b1;
      end else if (i == 300) begin
        sink_idles = 1'b0;
      end else if (i == 360) begin
        sink_idles = 1'b1;
      end
      s           = '0;
      s.req       = random_request();
      send_request(s);
    end

    req_if.valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[char_lcd_i2c_expander_formatter.f]
hdl/clie_pkg.sv
hdl/clie_if.sv
hdl/clie_front.sv
hdl/clie_queue.sv
hdl/clie_back.sv
hdl/char_lcd_i2c_expander_formatter.sv
hdl/clie_checker.sv
sim/tb.sv
